// File: hw/rtl/cdtc_pkg.sv
// ----------------------------------------------------------------------------
// cdtc_pkg
// shared types, field widths, calendar limits and the month length function
// ----------------------------------------------------------------------------
package cdtc_pkg;

    localparam int YEAR_W   = 16;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;

    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_SET  = 1'b1
    } t_cmd;

    // one input beat as held in the input register, plus the leap flag of its year
    typedef struct packed {
        t_cmd                cmd;
        logic [YEAR_W-1:0]   set_year;
        logic [MONTH_W-1:0]  set_month;
        logic [DAY_W-1:0]    set_day;
        logic [HOUR_W-1:0]   set_hour;
        logic [MINUTE_W-1:0] set_minute;
        logic [SECOND_W-1:0] set_second;
        logic                set_leap;
    } t_item;

    localparam int YEAR_RESET = 2000;

    localparam logic [SECOND_W-1:0] SECOND_MAX = 6'd59;
    localparam logic [MINUTE_W-1:0] MINUTE_MAX = 6'd59;
    localparam logic [HOUR_W-1:0]   HOUR_MAX   = 5'd23;
    localparam logic [MONTH_W-1:0]  MONTH_MIN  = 4'd1;
    localparam logic [MONTH_W-1:0]  MONTH_FEB  = 4'd2;
    localparam logic [MONTH_W-1:0]  MONTH_MAX  = 4'd12;
    localparam logic [DAY_W-1:0]    DAY_MIN    = 5'd1;
    localparam logic [DAY_W-1:0]    FEB_LEAP   = 5'd29;
    localparam logic [DAY_W-1:0]    FEB_COMMON = 5'd28;
    localparam logic [DAY_W-1:0]    DAY_LONG   = 5'd31;

    localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // multiplicative inverse of 25 modulo 2^16, good for any narrower width too
    localparam logic [YEAR_W-1:0] INV25 = 16'h5C29;

    // month length; months outside 1..12 give 31
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        logic [MONTH_W-1:0] idx;
        idx = m - MONTH_MIN;
        if (m == MONTH_FEB) begin
            len = leap ? FEB_LEAP : FEB_COMMON;
        end else if (m >= MONTH_MIN && m <= MONTH_MAX) begin
            len = MONTH_LEN[idx];
        end else begin
            len = DAY_LONG;
        end
        return len;
    endfunction

endpackage

// File: hw/rtl/cdtc_leap.sv
// ----------------------------------------------------------------------------
// cdtc_leap
// gregorian leap year detect (4/100/400 rule) for a year of YEAR_BITS bits
// ----------------------------------------------------------------------------
module cdtc_leap #(
    parameter int YEAR_BITS = 16
) (
    input  logic [YEAR_BITS-1:0] i_year,
    output logic                 o_leap
);
    import cdtc_pkg::*;

    localparam logic [YEAR_BITS-1:0] Inv      = YEAR_BITS'(INV25);
    localparam logic [YEAR_BITS-1:0] Div25Max = YEAR_BITS'(((1 << YEAR_BITS) - 1) / 25);

    logic [YEAR_BITS-1:0] w_prod;
    logic                 w_div4;
    logic                 w_div16;
    logic                 w_div25;

    // exact divisibility by 25: odd-constant inverse multiply, then range check
    assign w_prod  = i_year * Inv;
    assign w_div25 = (w_prod <= Div25Max);
    assign w_div4  = (i_year[1:0] == 2'b00);
    assign w_div16 = (i_year[3:0] == 4'b0000);

    // div by 100 = div4 & div25, div by 400 = div16 & div25
    assign o_leap = (w_div4 && !w_div25) || (w_div16 && w_div25);

endmodule

// File: hw/rtl/cdtc_in_reg.sv
// ----------------------------------------------------------------------------
// cdtc_in_reg
// input register stage; also works out the leap flag of the set year
// ----------------------------------------------------------------------------
module cdtc_in_reg #(
    parameter int YEAR_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  cdtc_pkg::t_cmd                i_cmd,
    input  logic [cdtc_pkg::YEAR_W-1:0]   i_set_year,
    input  logic [cdtc_pkg::MONTH_W-1:0]  i_set_month,
    input  logic [cdtc_pkg::DAY_W-1:0]    i_set_day,
    input  logic [cdtc_pkg::HOUR_W-1:0]   i_set_hour,
    input  logic [cdtc_pkg::MINUTE_W-1:0] i_set_minute,
    input  logic [cdtc_pkg::SECOND_W-1:0] i_set_second,
    input  logic                          i_next_ready,
    output logic                          o_item_vld,
    output cdtc_pkg::t_item               o_item
);
    import cdtc_pkg::*;

    logic  r_vld;
    t_item r_item;
    logic  w_set_leap;
    logic  w_load;

    cdtc_leap #(
        .YEAR_BITS (YEAR_BITS)
    ) u_leap (
        .i_year (i_set_year[YEAR_BITS-1:0]),
        .o_leap (w_set_leap)
    );

    assign o_stall = r_vld && !i_next_ready;
    assign w_load  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_load) begin
            r_vld <= 1'b1;
        end else if (i_next_ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item.cmd        <= i_cmd;
            r_item.set_year   <= i_set_year;
            r_item.set_month  <= i_set_month;
            r_item.set_day    <= i_set_day;
            r_item.set_hour   <= i_set_hour;
            r_item.set_minute <= i_set_minute;
            r_item.set_second <= i_set_second;
            r_item.set_leap   <= w_set_leap;
        end
    end

    assign o_item_vld = r_vld;
    assign o_item     = r_item;

endmodule

// File: hw/rtl/cdtc_time.sv
// ----------------------------------------------------------------------------
// cdtc_time
// time of day / date state, tick rollover and set check, result register
// ----------------------------------------------------------------------------
module cdtc_time #(
    parameter int YEAR_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_item_vld,
    input  cdtc_pkg::t_item               i_item,
    output logic                          o_ready,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_accepted,
    output logic [cdtc_pkg::YEAR_W-1:0]   o_now_year,
    output logic [cdtc_pkg::MONTH_W-1:0]  o_now_month,
    output logic [cdtc_pkg::DAY_W-1:0]    o_now_day,
    output logic [cdtc_pkg::HOUR_W-1:0]   o_now_hour,
    output logic [cdtc_pkg::MINUTE_W-1:0] o_now_minute,
    output logic [cdtc_pkg::SECOND_W-1:0] o_now_second
);
    import cdtc_pkg::*;

    // time state
    logic [YEAR_BITS-1:0] r_year,   n_year;
    logic [MONTH_W-1:0]   r_month,  n_month;
    logic [DAY_W-1:0]     r_day,    n_day;
    logic [HOUR_W-1:0]    r_hour,   n_hour;
    logic [MINUTE_W-1:0]  r_minute, n_minute;
    logic [SECOND_W-1:0]  r_second, n_second;
    logic                 r_leap;
    logic                 n_accepted;

    // result register
    logic                 r_out_vld;
    logic                 r_res_accepted;
    logic [YEAR_BITS-1:0] r_res_year;
    logic [MONTH_W-1:0]   r_res_month;
    logic [DAY_W-1:0]     r_res_day;
    logic [HOUR_W-1:0]    r_res_hour;
    logic [MINUTE_W-1:0]  r_res_minute;
    logic [SECOND_W-1:0]  r_res_second;

    logic                 w_fire;
    logic                 w_set_ok;
    logic                 w_load_set;
    logic                 w_leap_cur;
    logic [DAY_W-1:0]     w_set_len;
    logic [DAY_W-1:0]     w_cur_len;
    logic [YEAR_BITS-1:0] w_set_year;

    // leap flag of the held year, refreshed every cycle; only february needs it
    cdtc_leap #(
        .YEAR_BITS (YEAR_BITS)
    ) u_leap (
        .i_year (r_year),
        .o_leap (w_leap_cur)
    );

    assign o_ready    = !r_out_vld || !i_stall;
    assign w_fire     = i_item_vld && o_ready;
    assign w_set_year = i_item.set_year[YEAR_BITS-1:0];
    assign w_set_len  = month_len(i_item.set_month, i_item.set_leap);
    assign w_cur_len  = month_len(r_month, r_leap);

    assign w_set_ok = (i_item.set_month >= MONTH_MIN) && (i_item.set_month <= MONTH_MAX) &&
                      (i_item.set_day >= DAY_MIN) && (i_item.set_day <= w_set_len) &&
                      (i_item.set_hour <= HOUR_MAX) && (i_item.set_minute <= MINUTE_MAX) &&
                      (i_item.set_second <= SECOND_MAX);

    assign w_load_set = w_fire && (i_item.cmd == CMD_SET) && w_set_ok;

    always_comb begin
        n_year     = r_year;
        n_month    = r_month;
        n_day      = r_day;
        n_hour     = r_hour;
        n_minute   = r_minute;
        n_second   = r_second;
        n_accepted = 1'b1;
        unique case (i_item.cmd)
            CMD_TICK: begin
                if (r_second != SECOND_MAX) begin
                    n_second = r_second + 6'd1;
                end else begin
                    n_second = '0;
                    if (r_minute != MINUTE_MAX) begin
                        n_minute = r_minute + 6'd1;
                    end else begin
                        n_minute = '0;
                        if (r_hour != HOUR_MAX) begin
                            n_hour = r_hour + 5'd1;
                        end else begin
                            n_hour = '0;
                            if (r_day != w_cur_len) begin
                                n_day = r_day + 5'd1;
                            end else begin
                                n_day = DAY_MIN;
                                if (r_month != MONTH_MAX) begin
                                    n_month = r_month + 4'd1;
                                end else begin
                                    n_month = MONTH_MIN;
                                    n_year  = r_year + YEAR_BITS'(1);
                                end
                            end
                        end
                    end
                end
            end
            CMD_SET: begin
                if (w_set_ok) begin
                    n_year   = w_set_year;
                    n_month  = i_item.set_month;
                    n_day    = i_item.set_day;
                    n_hour   = i_item.set_hour;
                    n_minute = i_item.set_minute;
                    n_second = i_item.set_second;
                end else begin
                    n_accepted = 1'b0;
                end
            end
            default: begin
                n_accepted = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_year   <= YEAR_BITS'(YEAR_RESET);
            r_month  <= MONTH_MIN;
            r_day    <= DAY_MIN;
            r_hour   <= '0;
            r_minute <= '0;
            r_second <= '0;
            r_leap   <= 1'b1;    // 2000 is a leap year
        end else begin
            if (w_fire) begin
                r_year   <= n_year;
                r_month  <= n_month;
                r_day    <= n_day;
                r_hour   <= n_hour;
                r_minute <= n_minute;
                r_second <= n_second;
            end
            // a set may land on february right away, so take its flag directly
            if (w_load_set) begin
                r_leap <= i_item.set_leap;
            end else begin
                r_leap <= w_leap_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_fire) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_res_accepted <= n_accepted;
            r_res_year     <= n_year;
            r_res_month    <= n_month;
            r_res_day      <= n_day;
            r_res_hour     <= n_hour;
            r_res_minute   <= n_minute;
            r_res_second   <= n_second;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_accepted   = r_res_accepted;
    assign o_now_year   = YEAR_W'(r_res_year);
    assign o_now_month  = r_res_month;
    assign o_now_day    = r_res_day;
    assign o_now_hour   = r_res_hour;
    assign o_now_minute = r_res_minute;
    assign o_now_second = r_res_second;

    a_time_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second <= SECOND_MAX && r_minute <= MINUTE_MAX && r_hour <= HOUR_MAX &&
        r_month >= MONTH_MIN && r_month <= MONTH_MAX && r_day >= DAY_MIN)
        else $error("time state out of range");

    a_tick_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && i_item.cmd == CMD_TICK |=> r_res_accepted)
        else $error("tick beat reported as rejected");

    a_reject_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && i_item.cmd == CMD_SET && !w_set_ok |=>
        $stable(r_year) && $stable(r_month) && $stable(r_day) &&
        $stable(r_hour) && $stable(r_minute) && $stable(r_second))
        else $error("rejected set changed the time");

    a_result_tracks_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_res_year == r_year && r_res_day == r_day && r_res_second == r_second)
        else $error("result beat differs from time state");

endmodule

// File: hw/rtl/calendar_date_time_counter_unit.sv
// ----------------------------------------------------------------------------
// calendar_date_time_counter_unit
// gregorian real-time calendar counter with tick and checked set
// ----------------------------------------------------------------------------
// usage
//   input channel (i_valid / o_stall): each beat is a command. cmd tick
//   advances the time by one second with rollover through minutes, hours,
//   days (gregorian month lengths, 4/100/400 leap rule), months and years;
//   the year wraps to 0 past 2^YEAR_BITS - 1. cmd set loads all fields only
//   if every field is legal, otherwise the time stays as it was.
//   output channel (o_valid / i_stall): one beat per input beat, in order,
//   carrying the accepted flag and the time after that command.
//   an accepted input beat passes the input register, then the result
//   register, on its way to o_valid; throughput: one beat per cycle while
//   i_stall is low, as each update of the time registers is combinational.
//   reset (synchronous, active low) sets 2000-01-01 00:00:00 and empties
//   both stages. while i_stall is high the result beat holds; one more input
//   beat is still taken if the input register is empty, after that o_stall rises.
//   set_year above YEAR_BITS bits is cut to its low YEAR_BITS bits.
// ----------------------------------------------------------------------------
module calendar_date_time_counter_unit #(
    parameter int YEAR_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_cmd,
    input  logic [cdtc_pkg::YEAR_W-1:0]   i_set_year,
    input  logic [cdtc_pkg::MONTH_W-1:0]  i_set_month,
    input  logic [cdtc_pkg::DAY_W-1:0]    i_set_day,
    input  logic [cdtc_pkg::HOUR_W-1:0]   i_set_hour,
    input  logic [cdtc_pkg::MINUTE_W-1:0] i_set_minute,
    input  logic [cdtc_pkg::SECOND_W-1:0] i_set_second,
    // output channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_accepted,
    output logic [cdtc_pkg::YEAR_W-1:0]   o_now_year,
    output logic [cdtc_pkg::MONTH_W-1:0]  o_now_month,
    output logic [cdtc_pkg::DAY_W-1:0]    o_now_day,
    output logic [cdtc_pkg::HOUR_W-1:0]   o_now_hour,
    output logic [cdtc_pkg::MINUTE_W-1:0] o_now_minute,
    output logic [cdtc_pkg::SECOND_W-1:0] o_now_second
);
    import cdtc_pkg::*;

    // handoff between input register and time update stage
    logic  w_item_vld;
    logic  w_time_ready;
    t_item w_item;
    t_cmd  w_cmd;

    assign w_cmd = t_cmd'(i_cmd);

    // input register: holds one beat and its set-year leap flag
    cdtc_in_reg #(
        .YEAR_BITS (YEAR_BITS)
    ) u_in_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_cmd        (w_cmd),
        .i_set_year   (i_set_year),
        .i_set_month  (i_set_month),
        .i_set_day    (i_set_day),
        .i_set_hour   (i_set_hour),
        .i_set_minute (i_set_minute),
        .i_set_second (i_set_second),
        .i_next_ready (w_time_ready),
        .o_item_vld   (w_item_vld),
        .o_item       (w_item)
    );

    // time state update and result register
    cdtc_time #(
        .YEAR_BITS (YEAR_BITS)
    ) u_time (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_vld   (w_item_vld),
        .i_item       (w_item),
        .o_ready      (w_time_ready),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_accepted   (o_accepted),
        .o_now_year   (o_now_year),
        .o_now_month  (o_now_month),
        .o_now_day    (o_now_day),
        .o_now_hour   (o_now_hour),
        .o_now_minute (o_now_minute),
        .o_now_second (o_now_second)
    );

endmodule
